[hdl/trpd_pkg.sv]
// Shared types, codes and tables for the triac phase dimmer.
package trpd_pkg;

  localparam int COUNT_WIDTH_DEF  = 24;
  localparam int NUM_CHANNELS_DEF = 2;

  // Event codes carried in the func field
  localparam logic [2:0] FUNC_TICK       = 3'd0;
  localparam logic [2:0] FUNC_ZERO_CROSS = 3'd1;
  localparam logic [2:0] FUNC_BRIGHTER   = 3'd2;
  localparam logic [2:0] FUNC_DIMMER     = 3'd3;
  localparam logic [2:0] FUNC_SET_PCT    = 3'd4;
  localparam logic [2:0] FUNC_OFF        = 3'd5;
  localparam logic [2:0] FUNC_ON         = 3'd6;

  // Configuration register indexes
  localparam logic [1:0] CFG_TICKS_PER_US = 2'd0;
  localparam logic [1:0] CFG_CAP_DELAY_US = 2'd1;
  localparam logic [1:0] CFG_PULSE_TICKS  = 2'd2;

  localparam logic [2:0] LEVEL_OFF    = 3'd5;
  localparam logic [2:0] LEVEL_MIN_ON = 3'd4;

  localparam logic [7:0]  TICKS_PER_US_RST = 8'd1;
  localparam logic [13:0] CAP_DELAY_US_RST = 14'd0;
  localparam logic [15:0] PULSE_TICKS_RST  = 16'd1000;

  // Width of (cap_delay_us + delay) * ticks_per_us: 15 x 8 bits
  localparam int FIRE_PROD_W = 23;

  typedef struct packed {
    logic tick;
    logic arm;
  } trpd_chan_cmd_t;

  typedef struct packed {
    logic set_gate;
    logic clr_gate;
  } trpd_gate_ev_t;

  // Firing delay per level, microseconds
  function automatic logic [13:0] delay_us(input logic [2:0] lvl);
    logic [13:0] d;
    case (lvl)
      3'd0:    d = 14'd1197;
      3'd1:    d = 14'd2778;
      3'd2:    d = 14'd3633;
      3'd3:    d = 14'd4701;
      3'd4:    d = 14'd5874;
      default: d = 14'd8300;
    endcase
    return d;
  endfunction

  function automatic logic [6:0] level_pct(input logic [2:0] lvl);
    logic [6:0] p;
    case (lvl)
      3'd0:    p = 7'd100;
      3'd1:    p = 7'd80;
      3'd2:    p = 7'd60;
      3'd3:    p = 7'd40;
      3'd4:    p = 7'd20;
      default: p = 7'd0;
    endcase
    return p;
  endfunction

  // (120 - pct) / 20 - 1, saturating to level 0 above 100 percent
  function automatic logic [2:0] pct_to_level(input logic [6:0] pct);
    logic [2:0] l;
    if (pct > 7'd80)      l = 3'd0;
    else if (pct > 7'd60) l = 3'd1;
    else if (pct > 7'd40) l = 3'd2;
    else if (pct > 7'd20) l = 3'd3;
    else if (pct > 7'd0)  l = 3'd4;
    else                  l = LEVEL_OFF;
    return l;
  endfunction

endpackage

[hdl/trpd_level.sv]
// Brightness level, remembered level and lamp status.
module trpd_level (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [2:0] func_i,
  input  logic [6:0] pct_i,
  output logic [2:0] level_o,
  output logic [2:0] level_next_o,
  output logic       status_next_o
);
  import trpd_pkg::*;

  logic [2:0] level_q, level_d;
  logic [2:0] saved_q, saved_d;
  logic       status_q, status_d;
  logic [2:0] store_lvl;
  logic       do_store;

  always_comb begin
    level_d   = level_q;
    saved_d   = saved_q;
    status_d  = status_q;
    store_lvl = level_q;
    do_store  = 1'b0;
    unique case (func_i)
      FUNC_BRIGHTER: begin
        do_store  = 1'b1;
        store_lvl = (level_q != 3'd0) ? level_q - 3'd1 : 3'd0;
      end
      FUNC_DIMMER: begin
        do_store  = 1'b1;
        store_lvl = (level_q < LEVEL_OFF) ? level_q + 3'd1 : LEVEL_OFF;
      end
      FUNC_SET_PCT: begin
        do_store  = 1'b1;
        store_lvl = pct_to_level(pct_i);
      end
      FUNC_OFF: begin
        level_d  = LEVEL_OFF;
        status_d = 1'b0;
      end
      FUNC_ON: begin
        // nothing remembered: come on at the dimmest level
        if (saved_q >= LEVEL_OFF) begin
          level_d = LEVEL_MIN_ON;
          saved_d = LEVEL_MIN_ON;
        end else begin
          level_d = saved_q;
        end
        status_d = 1'b1;
      end
      default: ;
    endcase
    if (do_store) begin
      level_d  = store_lvl;
      saved_d  = store_lvl;
      status_d = (store_lvl != LEVEL_OFF);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= LEVEL_OFF;
      saved_q  <= LEVEL_OFF;
      status_q <= 1'b0;
    end else if (en_i) begin
      level_q  <= level_d;
      saved_q  <= saved_d;
      status_q <= status_d;
    end
  end

  assign level_o       = level_q;
  assign level_next_o  = level_d;
  assign status_next_o = status_d;

endmodule

[hdl/trpd_chan.sv]
// One-shot firing channel: delay count, then gate pulse count.
module trpd_chan #(
  parameter int COUNT_WIDTH = trpd_pkg::COUNT_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  trpd_pkg::trpd_chan_cmd_t cmd_i,
  input  logic [COUNT_WIDTH-1:0] arm_count_i,
  input  logic [15:0]            pulse_ticks_i,
  output trpd_pkg::trpd_gate_ev_t  ev_o
);
  import trpd_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_DELAY, PH_PULSE} phase_e;

  phase_e                 phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  trpd_gate_ev_t          ev;

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    ev      = '0;
    if (cmd_i.tick && phase_q != PH_IDLE) begin
      if (count_q != '0) begin
        count_d = count_q - COUNT_WIDTH'(1);
      end else if (phase_q == PH_DELAY) begin
        ev.set_gate = 1'b1;
        count_d     = COUNT_WIDTH'(pulse_ticks_i);
        phase_d     = PH_PULSE;
      end else begin
        ev.clr_gate = 1'b1;
        phase_d     = PH_IDLE;
      end
    end
    // rearm while pulsing reloads the count but keeps the gate on
    if (cmd_i.arm) begin
      count_d = arm_count_i;
      if (phase_q != PH_PULSE) phase_d = PH_DELAY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  assign ev_o = ev;

endmodule

[hdl/triac_phase_dimmer.sv]
// Top level of the triac phase dimmer: beat registers, firing count, gate.
//
// Usage:
//   s_axis carries one event per beat: func in tdata[2:0], percent in
//   tdata[9:3]. Every event gives exactly one result beat on m_axis:
//   gate, level, lamp_on and brightness_pct after that event.
//   The cfg channel writes ticks_per_us (index 0), cap_delay_us (1) and
//   pulse_ticks (2); cfg_ready_o is always high. Write only while idle.
// Timing:
//   An event is registered on acceptance and processed once the result
//   register is empty or being drained; its result is registered in the
//   result register. One event per clock is sustained while m_axis_tready_i
//   is high; level and channel state are updated once per event.
// Reset:
//   Level off (5), remembered level 5, lamp off, all channels idle,
//   gate released, config at 1 tick/us, no extra delay, 1000-tick pulse.
// Stall:
//   When m_axis_tready_i is low the result stays put, one more event
//   waits in the input register, and s_axis_tready_o drops.
module triac_phase_dimmer #(
  parameter int COUNT_WIDTH  = trpd_pkg::COUNT_WIDTH_DEF,
  parameter int NUM_CHANNELS = trpd_pkg::NUM_CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // func[2:0], percent[9:3], zeros
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // gate[0], level[3:1], lamp_on[4],
                                        // brightness_pct[11:5], zeros
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import trpd_pkg::*;

  localparam int NCH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int EXT_W = (COUNT_WIDTH > FIRE_PROD_W) ? COUNT_WIDTH : FIRE_PROD_W;
  localparam logic [NCH_W-1:0] LAST_CH = NCH_W'(NUM_CHANNELS - 1);

  // config registers
  logic [7:0]  tpu_q;
  logic [13:0] cap_q;
  logic [15:0] pulse_q;

  // input beat register
  logic       in_valid_q;
  logic [2:0] func_q;
  logic [6:0] pct_q;
  logic       s_accept, advance;

  // result register
  logic       out_valid_q;
  logic [11:0] out_q, out_d;

  // shared state
  logic             gate_q, gate_d;
  logic [NCH_W-1:0] next_ch_q, next_ch_d;

  logic [2:0]  level_cur, level_nxt;
  logic        status_nxt;
  logic [14:0] fire_sum;
  logic [FIRE_PROD_W-1:0] fire_prod;
  logic [EXT_W-1:0]       fire_ext;
  logic [COUNT_WIDTH-1:0] fire_count;
  logic        arm_ok;

  trpd_chan_cmd_t chan_cmd [NUM_CHANNELS];
  trpd_gate_ev_t  chan_ev  [NUM_CHANNELS];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpu_q   <= TICKS_PER_US_RST;
      cap_q   <= CAP_DELAY_US_RST;
      pulse_q <= PULSE_TICKS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TICKS_PER_US: tpu_q   <= cfg_data_i[7:0];
        CFG_CAP_DELAY_US: cap_q   <= cfg_data_i[13:0];
        CFG_PULSE_TICKS:  pulse_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: the event in the input register is processed when the
  // result register is empty or being drained this cycle.
  assign advance         = in_valid_q & (~out_valid_q | m_axis_tready_i);
  assign s_axis_tready_o = ~in_valid_q | advance;
  assign s_accept        = s_axis_tvalid_i & s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      func_q <= s_axis_tdata_i[2:0];
      pct_q  <= s_axis_tdata_i[9:3];
    end
  end

  trpd_level u_level (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (advance),
    .func_i        (func_q),
    .pct_i         (pct_q),
    .level_o       (level_cur),
    .level_next_o  (level_nxt),
    .status_next_o (status_nxt)
  );

  // Firing count: (cap + delay[level]) * ticks_per_us, saturated
  assign fire_sum  = {1'b0, cap_q} + {1'b0, delay_us(level_cur)};
  assign fire_prod = FIRE_PROD_W'(fire_sum) * FIRE_PROD_W'(tpu_q);
  assign fire_ext  = EXT_W'(fire_prod);
  assign fire_count = (fire_ext > EXT_W'({COUNT_WIDTH{1'b1}})) ?
                      {COUNT_WIDTH{1'b1}} : fire_ext[COUNT_WIDTH-1:0];

  // zero cross arms a channel only while the lamp level is not off
  assign arm_ok = (func_q == FUNC_ZERO_CROSS) && (level_cur < LEVEL_OFF);

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_chan
    assign chan_cmd[c].tick = advance && (func_q == FUNC_TICK);
    assign chan_cmd[c].arm  = advance && arm_ok && (next_ch_q == NCH_W'(c));

    trpd_chan #(
      .COUNT_WIDTH (COUNT_WIDTH)
    ) u_chan (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .en_i          (advance),
      .cmd_i         (chan_cmd[c]),
      .arm_count_i   (fire_count),
      .pulse_ticks_i (pulse_q),
      .ev_o          (chan_ev[c])
    );
  end

  // gate is shared: the highest-index channel event in a tick wins
  always_comb begin
    gate_d = gate_q;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (chan_ev[c].set_gate) gate_d = 1'b1;
      else if (chan_ev[c].clr_gate) gate_d = 1'b0;
    end
  end

  always_comb begin
    next_ch_d = next_ch_q;
    if (arm_ok) next_ch_d = (next_ch_q >= LAST_CH) ? '0 : next_ch_q + NCH_W'(1);
  end

  assign out_d = {level_pct(level_nxt), status_nxt, level_nxt, gate_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q      <= 1'b0;
      next_ch_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        gate_q    <= gate_d;
        next_ch_q <= next_ch_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_q <= out_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, out_q};

endmodule
